// ----- design/fwos_pkg.sv -----
package fwos_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH  = 16;
  localparam int unsigned DEF_RECORD_WIDTH = 32;

  localparam int unsigned TICK_W   = 32;
  localparam int unsigned AREA_W   = 48;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned MEAN_W   = 13;
  localparam int unsigned MEAN_MAX = 8191;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_RD,
    S_QST,
    S_DIV,
    S_DONE
  } state_e;

endpackage

// ----- design/fifo_with_occupancy_statistics_core.sv -----
// FIFO of records with time-weighted occupancy statistics. Each item carries an
// opcode (push, pop, query or none), the current tick and a record; every item gives
// one result with the popped record, occupancy, peak occupancy, the Q.8 mean
// occupancy (area sum over ticks, on query) and a status code. Items are handled
// one at a time: a push passes the multiply, accumulate and done states, a pop also
// reads the record memory, and a query also runs the radix-2 divider that produces
// one quotient bit per cycle. A new item is taken while the previous result still
// waits in the output register. Store entries hold no reset value.
module fifo_with_occupancy_statistics_core #(
  parameter int unsigned QUEUE_DEPTH  = fwos_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned RECORD_WIDTH = fwos_pkg::DEF_RECORD_WIDTH,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  opcode_i,
  input  logic [fwos_pkg::TICK_W-1:0] now_tick_i,
  input  logic [RECORD_WIDTH-1:0]     payload_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [RECORD_WIDTH-1:0]     pop_data_o,
  output logic                        pop_valid_o,
  output logic [CNT_W-1:0]            occupancy_o,
  output logic [CNT_W-1:0]            peak_occupancy_o,
  output logic [fwos_pkg::MEAN_W-1:0] mean_occupancy_q8_o,
  output logic [1:0]                  status_o
);

  import fwos_pkg::*;

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned PROD_W = CNT_W + TICK_W;
  localparam int unsigned CAP_FULL = QUEUE_DEPTH * (2 ** FRAC_W);
  localparam logic [MEAN_W-1:0] MEAN_CAP =
    (CAP_FULL > MEAN_MAX) ? MEAN_W'(MEAN_MAX) : MEAN_W'(CAP_FULL);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  state_e state_q, state_d;

  op_e               op_q;
  logic [TICK_W-1:0] now_q;
  logic [RECORD_WIDTH-1:0] payload_q;
  logic [TICK_W-1:0] elapsed_q;
  logic [PROD_W-1:0] prod_q;

  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  peak_q, peak_d;
  logic [TICK_W-1:0] last_q, last_d;
  logic [AREA_W-1:0] area_q, area_d;

  logic [RECORD_WIDTH-1:0] res_data_q;
  logic                    res_pvalid_q;
  status_e                 res_status_q, res_status_d;
  logic [MEAN_W-1:0]       res_mean_q;

  logic                    out_valid_q;
  logic [RECORD_WIDTH-1:0] out_data_q;
  logic                    out_pvalid_q;
  logic [CNT_W-1:0]        out_cnt_q;
  logic [CNT_W-1:0]        out_peak_q;
  logic [MEAN_W-1:0]       out_mean_q;
  status_e                 out_status_q;

  logic accept, acc_en, push_ok, pop_ok, mem_we, mem_re, div_start, load_out;
  logic div_done;
  logic [MEAN_W-1:0] div_quot;
  logic [RECORD_WIDTH-1:0] rdata;
  logic [AREA_W:0] area_sum;
  logic [TICK_W-1:0] elapsed_in;

  assign push_ok = (op_q == OP_PUSH) && (cnt_q != CNT_FULL);
  assign pop_ok  = (op_q == OP_POP) && (cnt_q != '0);
  assign accept  = in_valid_i && in_ready_o;
  assign elapsed_in = (now_tick_i >= last_q) ? (now_tick_i - last_q) : '0;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MUL;
      S_MUL:  state_d = S_ACC;
      S_ACC: begin
        if (pop_ok) begin
          state_d = S_RD;
        end else if (op_q == OP_QUERY && now_q != '0) begin
          state_d = S_QST;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RD:   state_d = S_DONE;
      S_QST:  state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_DONE;
      S_DONE: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    acc_en     = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_ACC:  acc_en = 1'b1;
      S_QST:  div_start = 1'b1;
      S_DONE: load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign mem_we = acc_en && push_ok;
  assign mem_re = acc_en && pop_ok;

  assign area_sum = {1'b0, area_q} + (AREA_W + 1)'(prod_q);

  // state update of the queue and statistics
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    peak_d = peak_q;
    last_d = last_q;
    area_d = area_q;
    res_status_d = ST_OK;
    if (acc_en && op_q != OP_NONE) begin
      last_d = now_q;
      area_d = area_sum[AREA_W] ? '1 : area_sum[AREA_W-1:0];
      case (op_q)
        OP_PUSH: begin
          if (push_ok) begin
            tail_d = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
            cnt_d  = cnt_q + 1'b1;
            if (cnt_d > peak_q) peak_d = cnt_d;
          end else begin
            res_status_d = ST_FULL;
          end
        end
        OP_POP: begin
          if (pop_ok) begin
            head_d = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
            cnt_d  = cnt_q - 1'b1;
          end else begin
            res_status_d = ST_EMPTY;
          end
        end
        OP_QUERY: begin
          if (now_q == '0) res_status_d = ST_ZERO;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      peak_q      <= '0;
      last_q      <= '0;
      area_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      peak_q  <= peak_d;
      last_q  <= last_d;
      area_q  <= area_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= op_e'(opcode_i);
      now_q        <= now_tick_i;
      payload_q    <= payload_i;
      elapsed_q    <= elapsed_in;
      res_data_q   <= '0;
      res_pvalid_q <= 1'b0;
      res_mean_q   <= '0;
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(cnt_q) * PROD_W'(elapsed_q);
    end
    if (acc_en) begin
      res_status_q <= res_status_d;
      res_pvalid_q <= pop_ok;
    end
    if (state_q == S_RD) begin
      res_data_q <= rdata;
    end
    if (state_q == S_DIV && div_done) begin
      res_mean_q <= (div_quot > MEAN_CAP) ? MEAN_CAP : div_quot;
    end
    if (load_out) begin
      out_data_q   <= res_data_q;
      out_pvalid_q <= res_pvalid_q;
      out_cnt_q    <= cnt_q;
      out_peak_q   <= peak_q;
      out_mean_q   <= res_mean_q;
      out_status_q <= res_status_q;
    end
  end

  fwos_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (RECORD_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_q),
    .wdata_i (payload_q),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  fwos_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (area_q),
    .divisor_i  (now_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_valid_o         = out_valid_q;
  assign pop_data_o          = out_data_q;
  assign pop_valid_o         = out_pvalid_q;
  assign occupancy_o         = out_cnt_q;
  assign peak_occupancy_o    = out_peak_q;
  assign mean_occupancy_q8_o = out_mean_q;
  assign status_o            = out_status_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("occupancy above queue depth");

  a_peak_ge_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= cnt_q)
    else $error("peak below occupancy");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CNT_FULL) |-> head_q == tail_q)
    else $error("pointers disagree with occupancy");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside a query");

endmodule

// ----- design/fwos_store.sv -----
module fwos_store #(
  parameter int unsigned DEPTH = fwos_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned WIDTH = fwos_pkg::DEF_RECORD_WIDTH,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/fwos_div.sv -----
module fwos_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fwos_pkg::AREA_W-1:0]  dividend_i,
  input  logic [fwos_pkg::TICK_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [fwos_pkg::MEAN_W-1:0]  quot_o
);

  import fwos_pkg::*;

  localparam int unsigned DIVD_W = AREA_W + FRAC_W;
  localparam int unsigned LIM_W  = TICK_W + MEAN_W;
  localparam int unsigned ITER_W = $clog2(MEAN_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [ITER_W-1:0] cnt_q;
  logic [TICK_W-1:0] rem_q, rem_d;
  logic [TICK_W-1:0] divisor_q;
  logic [MEAN_W-1:0] low_q;
  logic [MEAN_W-1:0] quot_q;

  logic [DIVD_W-1:0] dvd;
  logic [LIM_W-1:0]  lim;
  logic              ovf;
  logic [TICK_W:0]   trial;
  logic              ge;

  assign dvd = {dividend_i, FRAC_W'(0)};
  assign lim = {divisor_i, MEAN_W'(0)};
  // quotient would not fit in the mean field
  assign ovf = dvd >= DIVD_W'(lim);

  assign trial = {rem_q, low_q[MEAN_W-1]};
  assign ge    = trial >= {1'b0, divisor_q};

  always_comb begin
    if (ge) begin
      rem_d = TICK_W'(trial - {1'b0, divisor_q});
    end else begin
      rem_d = trial[TICK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (ovf) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= ITER_W'(MEAN_W);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      divisor_q <= divisor_i;
      rem_q     <= dvd[MEAN_W +: TICK_W];
      low_q     <= dvd[MEAN_W-1:0];
      quot_q    <= ovf ? '1 : '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      low_q  <= {low_q[MEAN_W-2:0], 1'b0};
      quot_q <= {quot_q[MEAN_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- test/fifo_with_occupancy_statistics_core_tb.sv -----
module fifo_with_occupancy_statistics_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fwos_pkg::*;

  localparam int unsigned DEPTH       = DEF_QUEUE_DEPTH;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned PRINT_LIMIT = 40;
  localparam int unsigned EXP_DEPTH   = 8;
  localparam logic [63:0] AREA_LIMIT  = (64'd1 << AREA_W) - 64'd1;

  typedef struct {
    logic [31:0]       pop_data;
    logic              pop_valid;
    logic [4:0]        occupancy;
    logic [4:0]        peak;
    logic [MEAN_W-1:0] mean;
    status_e           status;
  } fifo_result_t;

  logic              clk_i               = 1'b0;
  logic              rst_ni              = 1'b0;
  logic              in_valid_i          = 1'b0;
  logic              in_ready_o;
  logic [1:0]        opcode_i            = '0;
  logic [31:0]       now_tick_i          = '0;
  logic [31:0]       payload_i           = '0;
  logic              out_valid_o;
  logic              out_ready_i         = 1'b0;
  logic [31:0]       pop_data_o;
  logic              pop_valid_o;
  logic [4:0]        occupancy_o;
  logic [4:0]        peak_occupancy_o;
  logic [MEAN_W-1:0] mean_occupancy_q8_o;
  logic [1:0]        status_o;

  // mirror of the block state
  logic [31:0] record_mirror [DEPTH];
  int unsigned head_idx   = 0;
  int unsigned tail_idx   = 0;
  int unsigned held_cnt   = 0;
  int unsigned peak_cnt   = 0;
  logic [31:0] last_tick  = '0;
  logic [47:0] area_sum   = '0;

  // expected results in order of acceptance
  fifo_result_t exp_store [EXP_DEPTH];
  int unsigned  exp_wr_cnt     = 0;
  int unsigned  exp_rd_cnt     = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  bit           snd_idle_en    = 1'b1;
  bit           rcv_idle_en    = 1'b1;
  int unsigned  stall_left     = 0;

  fifo_with_occupancy_statistics_core u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .opcode_i            (opcode_i),
    .now_tick_i          (now_tick_i),
    .payload_i           (payload_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .pop_data_o          (pop_data_o),
    .pop_valid_o         (pop_valid_o),
    .occupancy_o         (occupancy_o),
    .peak_occupancy_o    (peak_occupancy_o),
    .mean_occupancy_q8_o (mean_occupancy_q8_o),
    .status_o            (status_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("fifo_with_occupancy_statistics_core verification failed");
      $finish;
    end
  end

  function automatic fifo_result_t predict_fifo_result(op_e op, logic [31:0] tick,
                                                        logic [31:0] data);
    fifo_result_t r;
    logic [63:0]  elapsed;
    logic [63:0]  area_next;
    logic [63:0]  quot;
    r.pop_data  = '0;
    r.pop_valid = 1'b0;
    r.mean      = '0;
    r.status    = ST_OK;
    if (op != OP_NONE) begin
      elapsed   = (tick >= last_tick) ? 64'(tick - last_tick) : 64'd0;
      area_next = 64'(area_sum) + 64'(held_cnt) * elapsed;
      area_sum  = (area_next > AREA_LIMIT) ? AREA_LIMIT[47:0] : area_next[47:0];
      last_tick = tick;
      case (op)
        OP_PUSH: begin
          if (held_cnt >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            record_mirror[tail_idx] = data;
            tail_idx = (tail_idx == DEPTH - 1) ? 0 : tail_idx + 1;
            held_cnt++;
            if (held_cnt > peak_cnt) peak_cnt = held_cnt;
          end
        end
        OP_POP: begin
          if (held_cnt == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.pop_data  = record_mirror[head_idx];
            r.pop_valid = 1'b1;
            head_idx = (head_idx == DEPTH - 1) ? 0 : head_idx + 1;
            held_cnt--;
          end
        end
        default: begin
          if (tick == '0) begin
            r.status = ST_ZERO;
          end else begin
            quot = (64'(area_sum) << FRAC_W) / 64'(tick);
            if (quot > 64'(DEPTH * 256)) quot = 64'(DEPTH * 256);
            if (quot > 64'(MEAN_MAX)) quot = 64'(MEAN_MAX);
            r.mean = quot[MEAN_W-1:0];
          end
        end
      endcase
    end
    r.occupancy = held_cnt[4:0];
    r.peak      = peak_cnt[4:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, exp_val);
    mismatch_count++;
  endtask

  // result checker, sampled on the falling edge before the accepting edge
  always @(negedge clk_i) begin
    fifo_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_wr_cnt == exp_rd_cnt) begin
        report_mismatch("unexpected result, occupancy", 64'(occupancy_o), 64'd0);
      end else begin
        exp_r = exp_store[exp_rd_cnt % EXP_DEPTH];
        exp_rd_cnt++;
        if (pop_data_o !== exp_r.pop_data)
          report_mismatch("pop_data", 64'(pop_data_o), 64'(exp_r.pop_data));
        if (pop_valid_o !== exp_r.pop_valid)
          report_mismatch("pop_valid", 64'(pop_valid_o), 64'(exp_r.pop_valid));
        if (occupancy_o !== exp_r.occupancy)
          report_mismatch("occupancy", 64'(occupancy_o), 64'(exp_r.occupancy));
        if (peak_occupancy_o !== exp_r.peak)
          report_mismatch("peak_occupancy", 64'(peak_occupancy_o), 64'(exp_r.peak));
        if (mean_occupancy_q8_o !== exp_r.mean)
          report_mismatch("mean_occupancy_q8", 64'(mean_occupancy_q8_o), 64'(exp_r.mean));
        if (status_o !== exp_r.status)
          report_mismatch("status", 64'(status_o), 64'(exp_r.status));
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (rcv_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_item(input op_e op, input logic [31:0] tick, input logic [31:0] data);
    bit rdy;
    if (snd_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    now_tick_i <= tick;
    payload_i  <= data;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    exp_store[exp_wr_cnt % EXP_DEPTH] = predict_fifo_result(op, tick, data);
    exp_wr_cnt++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (exp_wr_cnt != exp_rd_cnt) @(posedge clk_i);
  endtask

  task automatic test_basic_ops();
    send_item(OP_QUERY, 32'd0, 32'd0);
    send_item(OP_POP, 32'd5, 32'd0);
    send_item(OP_PUSH, 32'd10, 32'h0000_0000);
    send_item(OP_PUSH, 32'd20, 32'hFFFF_FFFF);
    send_item(OP_NONE, 32'd1000, 32'h1234_5678);
    send_item(OP_QUERY, 32'd500, 32'd0);
    send_item(OP_POP, 32'd600, 32'd0);
    send_item(OP_PUSH, 32'd700, 32'hA5A5_A5A5);
    send_item(OP_QUERY, 32'hFFFF_FFFF, 32'd0);
    send_item(OP_POP, 32'd100, 32'd0);
    send_item(OP_POP, 32'd200, 32'd0);
    send_item(OP_POP, 32'd300, 32'd0);
    send_item(OP_QUERY, 32'd0, 32'd0);
    send_item(OP_PUSH, 32'h8000_0000, 32'h5A5A_5A5A);
    send_item(OP_QUERY, 32'd1, 32'd0);
    send_item(OP_POP, 32'h8000_0001, 32'd0);
    send_item(OP_NONE, 32'd0, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 32'h8000_0002, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned counted;
    int unsigned push_pct;
    int unsigned r;
    op_e         op;
    logic [31:0] tick;
    counted = 0;
    tick    = last_tick;
    while (counted < n_items) begin
      push_pct = ($urandom_range(0, 2) == 0) ? 50 : ($urandom_range(0, 1) ? 80 : 20);
      snd_idle_en = ($urandom_range(0, 3) != 0);
      rcv_idle_en = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(8, 48)) begin
        r = $urandom_range(0, 99);
        if (r < 3) op = OP_NONE;
        else if (r < 13) op = OP_QUERY;
        else if ($urandom_range(0, 99) < push_pct) op = OP_PUSH;
        else op = OP_POP;
        r = $urandom_range(0, 99);
        if (r < 80) tick = tick + $urandom_range(0, 16);
        else if (r < 90) tick = tick + $urandom_range(0, 65535);
        else if (r < 95) tick = $urandom();
        else if (r < 98) tick = '0;
        else tick = '1;
        send_item(op, tick, $urandom());
        if (op != OP_NONE) counted++;
      end
    end
  endtask

  // full queue and alternating extreme ticks build a large area sum
  task automatic test_large_area();
    snd_idle_en = 1'b0;
    rcv_idle_en = 1'b0;
    while (held_cnt < DEPTH) send_item(OP_PUSH, last_tick, $urandom());
    for (int i = 0; i < 100; i++) begin
      send_item(OP_PUSH, 32'hFFFF_FFFF, $urandom());
      if (i % 25 == 0) send_item(OP_QUERY, 32'hFFFF_FFFF, 32'd0);
      send_item(OP_PUSH, 32'd0, $urandom());
    end
    send_item(OP_QUERY, 32'hFFFF_FFFF, 32'd0);
    send_item(OP_QUERY, 32'd1, 32'd0);
    send_item(OP_QUERY, 32'd0, 32'd0);
    send_item(OP_POP, 32'h7FFF_FFFF, 32'd0);
    send_item(OP_QUERY, 32'h8000_0000, 32'd0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    wait_drained();
    test_random_traffic(180);
    wait_drained();
    test_random_traffic(180);
    wait_drained();
    test_large_area();
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && exp_wr_cnt == exp_rd_cnt) begin
      $display("fifo_with_occupancy_statistics_core verification clean");
    end else begin
      $display("fifo_with_occupancy_statistics_core verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/fwos_pkg.sv
design/fwos_store.sv
design/fwos_div.sv
design/fifo_with_occupancy_statistics_core.sv
test/fifo_with_occupancy_statistics_core_tb.sv
